@@ rtl/tcw_pkg.sv @@
package tcw_pkg;

    // Screen geometry
    localparam int unsigned COLUMNS = 80;
    localparam int unsigned ROWS    = 25;
    localparam int unsigned CELLS   = COLUMNS * ROWS;

    // Widths that follow from the geometry
    localparam int unsigned ADDR_W = $clog2(CELLS);
    localparam int unsigned POS_W  = $clog2(CELLS + 1);
    localparam int unsigned COL_W  = $clog2(COLUMNS);
    localparam int unsigned ROW_W  = $clog2(ROWS + 1);
    localparam int unsigned CELL_W = 16;

    // Character codes
    localparam logic [7:0] SPACE_CODE = 8'h20;
    localparam logic [7:0] CR_CODE    = 8'h0D;
    localparam logic [7:0] LF_CODE    = 8'h0A;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;
        logic do_pre;
        logic scroll_start;
        logic do_char;
        logic copy_step;
        logic fill_step;
        logic clear_step;
        logic clear_zero;
        logic read_issue;
        logic cursor_clear;
        logic load_result;
    } tcw_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pos_pending;
        logic lf_last;
        logic copy_last;
        logic fill_last;
        logic clear_last;
        logic out_free;
    } tcw_sts_t;

endpackage

@@ rtl/tcw_ram.sv @@
module tcw_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/tcw_ctrl.sv @@
module tcw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        kind,
    input  tcw_pkg::tcw_sts_t sts,
    output tcw_pkg::tcw_cmd_t cmd
);

    import tcw_pkg::*;

    typedef enum logic [8:0] {
        ST_INIT  = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_CHAR  = 9'b000000100,
        ST_COPY  = 9'b000001000,
        ST_DRAIN = 9'b000010000,
        ST_FILL  = 9'b000100000,
        ST_CLEAR = 9'b001000000,
        ST_READ  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   pre_reg, pre_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Sequence each word through its steps
    always_comb
    begin
        state_next = state_reg;
        pre_next   = pre_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.clear_step = 1'b1;
                cmd.clear_zero = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.latch = 1'b1;
                    case (kind)
                        KIND_CHAR:
                        begin
                            if (sts.pos_pending)
                            begin
                                cmd.do_pre       = 1'b1;
                                cmd.scroll_start = 1'b1;
                                pre_next         = 1'b1;
                                state_next       = ST_COPY;
                            end
                            else
                            begin
                                state_next = ST_CHAR;
                            end
                        end
                        KIND_CLEAR: state_next = ST_CLEAR;
                        KIND_READ:  state_next = ST_READ;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_CHAR:
            begin
                cmd.do_char = 1'b1;
                pre_next    = 1'b0;
                if (sts.lf_last)
                begin
                    cmd.scroll_start = 1'b1;
                    state_next       = ST_COPY;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (sts.copy_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (sts.fill_last)
                begin
                    state_next = pre_reg ? ST_CHAR : ST_DONE;
                end
            end
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    cmd.cursor_clear = 1'b1;
                    state_next       = ST_DONE;
                end
            end
            ST_READ:
            begin
                cmd.read_issue = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            pre_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pre_reg   <= pre_next;
        end
    end

endmodule

@@ rtl/tcw_datapath.sv @@
module tcw_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  tcw_pkg::tcw_cmd_t cmd,
    output tcw_pkg::tcw_sts_t sts,
    input  logic [1:0]        kind,
    input  logic [7:0]        char_code,
    input  logic [7:0]        attribute,
    input  logic [10:0]       cell_index,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [10:0]       cursor_position,
    output logic [7:0]        read_char,
    output logic [7:0]        read_attribute,
    output logic [1:0]        scroll_count
);

    import tcw_pkg::*;

    // Latched word
    logic [1:0]        kind_reg;
    logic [7:0]        char_reg;
    logic [7:0]        attr_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic              idx_ok_reg;

    // Cursor, kept as linear position and as row and column
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;

    // Sweep counter and scroll state
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              wr_pend_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic [7:0]        fill_attr_reg;
    logic [1:0]        scroll_reg, scroll_next;

    // Result register
    logic              out_valid_reg;
    logic [10:0]       cursor_position_reg;
    logic [7:0]        read_char_reg;
    logic [7:0]        read_attribute_reg;
    logic [1:0]        scroll_count_reg;

    // Memory port signals
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic [CELL_W-1:0] rdata;

    logic              is_cr;
    logic              is_lf;
    logic              row_last;
    logic              cnt_last_copy;
    logic              cnt_last_fill;
    logic              cnt_last_clear;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign is_cr          = (char_reg == CR_CODE);
    assign is_lf          = (char_reg == LF_CODE);
    assign row_last       = (row_reg >= ROW_W'(ROWS - 1));
    assign cnt_last_copy  = (cnt_reg == ADDR_W'(CELLS - COLUMNS - 1));
    assign cnt_last_fill  = (cnt_reg == ADDR_W'(COLUMNS - 1));
    assign cnt_last_clear = (cnt_reg == ADDR_W'(CELLS - 1));

    always_comb
    begin
        sts.pos_pending = (pos_reg == POS_W'(CELLS));
        sts.lf_last     = is_lf && row_last;
        sts.copy_last   = cnt_last_copy;
        sts.fill_last   = cnt_last_fill;
        sts.clear_last  = cnt_last_clear;
        sts.out_free    = !out_valid_reg || out_ready;
    end

    // Select the single write of this cycle
    always_comb
    begin
        we    = 1'b0;
        waddr = cnt_reg;
        wdata = {fill_attr_reg, SPACE_CODE};
        if (wr_pend_reg)
        begin
            we    = 1'b1;
            waddr = wr_addr_reg;
            wdata = rdata;
        end
        else if (cmd.fill_step)
        begin
            we    = 1'b1;
            waddr = ADDR_W'(CELLS - COLUMNS) + cnt_reg;
            wdata = {fill_attr_reg, SPACE_CODE};
        end
        else if (cmd.clear_step)
        begin
            we    = 1'b1;
            waddr = cnt_reg;
            wdata = cmd.clear_zero ? '0 : {attr_reg, SPACE_CODE};
        end
        else if (cmd.do_char && !is_cr && !is_lf)
        begin
            we    = 1'b1;
            waddr = pos_reg[ADDR_W-1:0];
            wdata = {attr_reg, char_reg};
        end
    end

    // Read one row ahead while copying, else the requested cell
    assign re    = cmd.copy_step || (cmd.read_issue && idx_ok_reg);
    assign raddr = cmd.copy_step ? (cnt_reg + ADDR_W'(COLUMNS)) : idx_reg;

    // Advance the sweep counter, wrapping to zero at the end of each pass
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.copy_step)
        begin
            cnt_next = cnt_last_copy ? '0 : cnt_reg + 1'b1;
        end
        else if (cmd.fill_step)
        begin
            cnt_next = cnt_last_fill ? '0 : cnt_reg + 1'b1;
        end
        else if (cmd.clear_step)
        begin
            cnt_next = cnt_last_clear ? '0 : cnt_reg + 1'b1;
        end
    end

    // Move the cursor
    always_comb
    begin
        pos_next = pos_reg;
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.cursor_clear)
        begin
            pos_next = '0;
            col_next = '0;
            row_next = '0;
        end
        else if (cmd.do_pre)
        begin
            pos_next = pos_reg - POS_W'(COLUMNS);
            row_next = row_reg - 1'b1;
        end
        else if (cmd.do_char)
        begin
            if (is_cr)
            begin
                pos_next = pos_reg - POS_W'(col_reg);
                col_next = '0;
            end
            else if (is_lf)
            begin
                if (!row_last)
                begin
                    pos_next = pos_reg + POS_W'(COLUMNS);
                    row_next = row_reg + 1'b1;
                end
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                if (col_reg == COL_W'(COLUMNS - 1))
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
        end
    end

    assign scroll_next = (cmd.latch ? 2'd0 : scroll_reg) + {1'b0, cmd.scroll_start};

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            wr_pend_reg   <= 1'b0;
            scroll_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            cnt_reg     <= cnt_next;
            wr_pend_reg <= cmd.copy_step;
            scroll_reg  <= scroll_next;
            if (cmd.load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg   <= kind;
            char_reg   <= char_code;
            attr_reg   <= attribute;
            idx_reg    <= ADDR_W'(cell_index);
            idx_ok_reg <= (32'(cell_index) < CELLS);
        end
        if (cmd.copy_step)
        begin
            wr_addr_reg <= cnt_reg;
        end
        // Bottom row takes the attribute of cell 0 after the shift
        if (wr_pend_reg && (wr_addr_reg == '0))
        begin
            fill_attr_reg <= rdata[15:8];
        end
        if (cmd.load_result)
        begin
            cursor_position_reg <= 11'(pos_reg);
            scroll_count_reg    <= scroll_reg;
            if ((kind_reg == KIND_READ) && idx_ok_reg)
            begin
                read_char_reg      <= rdata[7:0];
                read_attribute_reg <= rdata[15:8];
            end
            else
            begin
                read_char_reg      <= '0;
                read_attribute_reg <= '0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign cursor_position = cursor_position_reg;
    assign read_char       = read_char_reg;
    assign read_attribute  = read_attribute_reg;
    assign scroll_count    = scroll_count_reg;

endmodule

@@ rtl/text_console_writer.sv @@
// Text-mode console with an 80 x 25 cell screen store and a cursor.
// Input channel (in_valid / in_ready) takes one word: kind, char_code,
// attribute and cell_index. Output channel (out_valid / out_ready) gives one
// word per input word: cursor_position, read_char, read_attribute and
// scroll_count.
// A carriage return, line feed, ordinary character or read goes through
// one work state and the done state, where the result is loaded into the
// output register; an unused kind goes straight to the done state and a
// clear first sweeps every cell. A scroll copies the rows up one cell a cycle
// through the single read and single write port of the screen memory, then
// fills the bottom row. One word is in work at a time; in_ready is high only
// between words, so a new word waits until the previous one is done.
// The finished result sits in an output register, so a new word is taken
// while an earlier result still waits for out_ready. If the receiver stalls,
// the next result holds inside the block, with in_ready low, until the
// register is free.
// After reset the screen memory is swept to zero; in_ready stays low until
// the sweep ends. The cursor resets to cell 0.
module text_console_writer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  char_code,
    input  logic [7:0]  attribute,
    input  logic [10:0] cell_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [10:0] cursor_position,
    output logic [7:0]  read_char,
    output logic [7:0]  read_attribute,
    output logic [1:0]  scroll_count
);

    import tcw_pkg::*;

    tcw_cmd_t cmd;
    tcw_sts_t sts;

    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcw_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .kind            (kind),
        .char_code       (char_code),
        .attribute       (attribute),
        .cell_index      (cell_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .cursor_position (cursor_position),
        .read_char       (read_char),
        .read_attribute  (read_attribute),
        .scroll_count    (scroll_count)
    );

endmodule
